FILE: sv/ccflru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ccflru_pkg;
  localparam int SLOTS_DEF = 64;
  localparam int CAP_W     = 7;
  localparam int LPN_W     = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] HIT_MISS  = 2'd0;
  localparam logic [1:0] HIT_CLEAN = 2'd1;
  localparam logic [1:0] HIT_MIXED = 2'd2;
endpackage
`default_nettype wire

FILE: sv/ccflru_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ccflru_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/cold_clean_first_lru_policy.sv
// Cold-clean-first LRU replacement engine for a flash page buffer.
// Input: pulse start with in_lpn / in_req_type (0 write, 1 read) while busy
// is low; the item is taken on that edge and busy rises.
// Output: one result per item, shown for exactly one cycle with out_valid
// (hit kind, fetch flag, evicted page and its write-back flag). The
// receiver cannot stall; busy drops in the same cycle the result shows.
// Config: cfg_we / cfg_wdata writes the capacity (0 acts as 1, values
// above SLOTS act as SLOTS); write only while busy is low.
// Operation: the tag lookup compares one stored page per cycle through the
// single page RAM read port. A hit then relinks the lists: it reads the
// links, unlinks the page and pushes it on the mixed front. A miss with a
// full buffer evicts: a cold-clean victim is dropped from the clean tail,
// while a walk of the mixed list moves pages (up to 2*occupancy+2 moves)
// until it finds a victim. Insertion then writes the page and pushes it.
// Reset (rst_n low, synchronous) empties both lists, invalidates every
// slot and sets capacity to 64; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module cold_clean_first_lru_policy #(
  parameter int SLOTS = ccflru_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ccflru_pkg::LPN_W-1:0]  in_lpn,
  input  wire logic                          in_req_type,
  output logic                               out_valid,
  output logic [1:0]                         out_hit_kind,
  output logic                               out_fetch_needed,
  output logic                               out_evict_valid,
  output logic [ccflru_pkg::LPN_W-1:0]       out_evict_lpn,
  output logic                               out_evict_writeback,
  input  wire logic                          cfg_we,
  input  wire logic [ccflru_pkg::CAP_W-1:0]  cfg_wdata
);
  import ccflru_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int BW = $clog2(2 * SLOTS + 3);
  localparam int KW = ((CW + 1) > (CAP_W + 1)) ? (CW + 1) : (CAP_W + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_EVICT  = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_REM_RD = 4'd4;
  localparam logic [3:0] S_REM_EX = 4'd5;
  localparam logic [3:0] S_PUSH   = 4'd6;
  localparam logic [3:0] S_INSERT = 4'd7;

  localparam logic [1:0] OP_HIT  = 2'd0;
  localparam logic [1:0] OP_WALK = 2'd1;
  localparam logic [1:0] OP_INS  = 2'd2;

  logic [3:0]       state_r, state_nxt;
  logic [LPN_W-1:0] lpn_r, lpn_nxt;
  logic             wr_r, wr_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [IW-1:0]    scan_idx_r, scan_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;
  logic [IW-1:0]    ev_slot_r, ev_slot_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic             push_clean_r, push_clean_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             drop_r, drop_nxt;
  logic [BW-1:0]    iter_r, iter_nxt;
  logic [BW-1:0]    bound_r, bound_nxt;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] dirty_r, dirty_nxt;
  logic [SLOTS-1:0] cold_r, cold_nxt;
  logic [SLOTS-1:0] incl_r, incl_nxt;

  logic [IW-1:0] clean_front_r, clean_front_nxt, clean_tail_r, clean_tail_nxt;
  logic [IW-1:0] mixed_front_r, mixed_front_nxt, mixed_tail_r, mixed_tail_nxt;
  logic [CW-1:0] clean_cnt_r, clean_cnt_nxt, mixed_cnt_r, mixed_cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_hit_r, out_hit_nxt;
  logic             out_fetch_r, out_fetch_nxt;
  logic             out_ev_valid_r, out_ev_valid_nxt;
  logic [LPN_W-1:0] out_ev_lpn_r, out_ev_lpn_nxt;
  logic             out_ev_wb_r, out_ev_wb_nxt;

  // RAM ports
  logic             page_we;
  logic [IW-1:0]    page_waddr, page_raddr;
  logic [LPN_W-1:0] page_rdata;
  logic             older_we, newer_we;
  logic [IW-1:0]    older_waddr, newer_waddr, older_wdata, newer_wdata;
  logic [IW-1:0]    older_rdata, newer_rdata;

  // list view used by remove / push
  logic          sel_clean;
  logic [IW-1:0] l_front, l_tail;
  logic [CW-1:0] l_cnt;

  logic [KW-1:0] total, cap_eff;
  logic          ins_ok;
  logic [IW-1:0] ins_slot;

  ccflru_ram #(.W(LPN_W), .D(SLOTS)) u_page (
    .clk(clk), .we(page_we), .waddr(page_waddr), .wdata(lpn_r),
    .raddr(page_raddr), .rdata(page_rdata)
  );
  ccflru_ram #(.W(IW), .D(SLOTS)) u_older (
    .clk(clk), .we(older_we), .waddr(older_waddr), .wdata(older_wdata),
    .raddr(cur_r), .rdata(older_rdata)
  );
  ccflru_ram #(.W(IW), .D(SLOTS)) u_newer (
    .clk(clk), .we(newer_we), .waddr(newer_waddr), .wdata(newer_wdata),
    .raddr(cur_r), .rdata(newer_rdata)
  );

  always_comb begin
    total = KW'(clean_cnt_r) + KW'(mixed_cnt_r);
    if (cap_r == '0) begin
      cap_eff = KW'(1);
    end else if (KW'(cap_r) > KW'(SLOTS)) begin
      cap_eff = KW'(SLOTS);
    end else begin
      cap_eff = KW'(cap_r);
    end
  end

  // lowest free slot: first hole seen in the scan, or the slot just freed
  always_comb begin
    ins_ok   = 1'b1;
    ins_slot = free_idx_r;
    if (free_found_r && (!out_ev_valid_r || free_idx_r < ev_slot_r)) begin
      ins_slot = free_idx_r;
    end else if (out_ev_valid_r) begin
      ins_slot = ev_slot_r;
    end else begin
      ins_ok = 1'b0;
    end
  end

  always_comb begin
    sel_clean = (state_r == S_PUSH) ? push_clean_r : incl_r[cur_r];
    l_front   = sel_clean ? clean_front_r : mixed_front_r;
    l_tail    = sel_clean ? clean_tail_r  : mixed_tail_r;
    l_cnt     = sel_clean ? clean_cnt_r   : mixed_cnt_r;
  end

  always_comb begin
    state_nxt       = state_r;
    lpn_nxt         = lpn_r;
    wr_nxt          = wr_r;
    cap_nxt         = cfg_we ? cfg_wdata : cap_r;
    scan_idx_nxt    = scan_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    ev_slot_nxt     = ev_slot_r;
    cur_nxt         = cur_r;
    push_clean_nxt  = push_clean_r;
    op_nxt          = op_r;
    drop_nxt        = drop_r;
    iter_nxt        = iter_r;
    bound_nxt       = bound_r;
    valid_nxt       = valid_r;
    dirty_nxt       = dirty_r;
    cold_nxt        = cold_r;
    incl_nxt        = incl_r;
    clean_front_nxt = clean_front_r;
    clean_tail_nxt  = clean_tail_r;
    mixed_front_nxt = mixed_front_r;
    mixed_tail_nxt  = mixed_tail_r;
    clean_cnt_nxt   = clean_cnt_r;
    mixed_cnt_nxt   = mixed_cnt_r;
    out_valid_nxt   = 1'b0;
    out_hit_nxt     = out_hit_r;
    out_fetch_nxt   = out_fetch_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_lpn_nxt  = out_ev_lpn_r;
    out_ev_wb_nxt   = out_ev_wb_r;

    page_we     = 1'b0;
    page_waddr  = ins_slot;
    page_raddr  = cur_r;
    older_we    = 1'b0;
    older_waddr = cur_r;
    older_wdata = l_front;
    newer_we    = 1'b0;
    newer_waddr = l_front;
    newer_wdata = cur_r;

    case (state_r)
      S_IDLE: begin
        page_raddr = '0;
        if (start) begin
          lpn_nxt          = in_lpn;
          wr_nxt           = !in_req_type;
          scan_idx_nxt     = '0;
          free_found_nxt   = 1'b0;
          out_hit_nxt      = HIT_MISS;
          out_fetch_nxt    = 1'b0;
          out_ev_valid_nxt = 1'b0;
          out_ev_lpn_nxt   = '0;
          out_ev_wb_nxt    = 1'b0;
          state_nxt        = S_SCAN;
        end
      end

      S_SCAN: begin
        page_raddr   = scan_idx_r + IW'(1);
        scan_idx_nxt = scan_idx_r + IW'(1);
        if (valid_r[scan_idx_r] && page_rdata == lpn_r) begin
          out_hit_nxt = incl_r[scan_idx_r] ? HIT_CLEAN : HIT_MIXED;
          cold_nxt[scan_idx_r] = 1'b0;
          if (wr_r) begin
            dirty_nxt[scan_idx_r] = 1'b1;
          end
          cur_nxt        = scan_idx_r;
          push_clean_nxt = 1'b0;
          op_nxt         = OP_HIT;
          drop_nxt       = 1'b0;
          state_nxt      = S_REM_RD;
        end else begin
          if (!valid_r[scan_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = scan_idx_r;
          end
          if (scan_idx_r == IW'(SLOTS - 1)) begin
            out_fetch_nxt = 1'b1;
            state_nxt     = (total >= cap_eff) ? S_EVICT : S_INSERT;
          end
        end
      end

      S_EVICT: begin
        op_nxt = OP_WALK;
        if (clean_cnt_r != '0) begin
          cur_nxt   = clean_tail_r;
          drop_nxt  = 1'b1;
          state_nxt = S_REM_RD;
        end else begin
          iter_nxt  = '0;
          bound_nxt = BW'({mixed_cnt_r, 1'b0}) + BW'(2);
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if (iter_r < bound_r && mixed_cnt_r != '0) begin
          cur_nxt   = mixed_tail_r;
          state_nxt = S_REM_RD;
          drop_nxt  = 1'b0;
          if (!cold_r[mixed_tail_r]) begin
            cold_nxt[mixed_tail_r] = 1'b1;
            push_clean_nxt = 1'b0;
          end else if (!dirty_r[mixed_tail_r]) begin
            push_clean_nxt = 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
        end else if (clean_cnt_r != '0) begin
          cur_nxt   = clean_tail_r;
          drop_nxt  = 1'b1;
          state_nxt = S_REM_RD;
        end else begin
          state_nxt = S_INSERT;
        end
      end

      S_REM_RD: begin
        state_nxt = S_REM_EX;
      end

      S_REM_EX: begin
        // older_rdata / newer_rdata are the links of cur
        if (l_cnt != '0) begin
          if (l_cnt > CW'(1)) begin
            if (cur_r == l_front) begin
              if (sel_clean) clean_front_nxt = older_rdata;
              else           mixed_front_nxt = older_rdata;
            end else if (cur_r == l_tail) begin
              if (sel_clean) clean_tail_nxt = newer_rdata;
              else           mixed_tail_nxt = newer_rdata;
            end else begin
              newer_we    = 1'b1;
              newer_waddr = older_rdata;
              newer_wdata = newer_rdata;
              older_we    = 1'b1;
              older_waddr = newer_rdata;
              older_wdata = older_rdata;
            end
          end
          if (sel_clean) clean_cnt_nxt = clean_cnt_r - CW'(1);
          else           mixed_cnt_nxt = mixed_cnt_r - CW'(1);
        end
        if (drop_r) begin
          out_ev_valid_nxt = 1'b1;
          out_ev_lpn_nxt   = page_rdata;
          out_ev_wb_nxt    = dirty_r[cur_r];
          ev_slot_nxt      = cur_r;
          valid_nxt[cur_r] = 1'b0;
          dirty_nxt[cur_r] = 1'b0;
          cold_nxt[cur_r]  = 1'b0;
          incl_nxt[cur_r]  = 1'b0;
          state_nxt        = S_INSERT;
        end else begin
          state_nxt = S_PUSH;
        end
      end

      S_PUSH: begin
        incl_nxt[cur_r] = push_clean_r;
        if (l_cnt == '0) begin
          if (push_clean_r) begin
            clean_front_nxt = cur_r;
            clean_tail_nxt  = cur_r;
          end else begin
            mixed_front_nxt = cur_r;
            mixed_tail_nxt  = cur_r;
          end
        end else begin
          newer_we = 1'b1;
          older_we = 1'b1;
          if (push_clean_r) clean_front_nxt = cur_r;
          else              mixed_front_nxt = cur_r;
        end
        if (push_clean_r) clean_cnt_nxt = clean_cnt_r + CW'(1);
        else              mixed_cnt_nxt = mixed_cnt_r + CW'(1);
        if (op_r == OP_WALK) begin
          iter_nxt  = iter_r + BW'(1);
          state_nxt = S_WALK;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_INSERT: begin
        if (ins_ok) begin
          page_we             = 1'b1;
          valid_nxt[ins_slot] = 1'b1;
          cold_nxt[ins_slot]  = 1'b1;
          dirty_nxt[ins_slot] = wr_r;
          cur_nxt             = ins_slot;
          push_clean_nxt      = !wr_r;
          op_nxt              = OP_INS;
          state_nxt           = S_PUSH;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cap_r         <= CAP_RESET;
      valid_r       <= '0;
      dirty_r       <= '0;
      cold_r        <= '0;
      incl_r        <= '0;
      clean_front_r <= '0;
      clean_tail_r  <= '0;
      mixed_front_r <= '0;
      mixed_tail_r  <= '0;
      clean_cnt_r   <= '0;
      mixed_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cap_r         <= cap_nxt;
      valid_r       <= valid_nxt;
      dirty_r       <= dirty_nxt;
      cold_r        <= cold_nxt;
      incl_r        <= incl_nxt;
      clean_front_r <= clean_front_nxt;
      clean_tail_r  <= clean_tail_nxt;
      mixed_front_r <= mixed_front_nxt;
      mixed_tail_r  <= mixed_tail_nxt;
      clean_cnt_r   <= clean_cnt_nxt;
      mixed_cnt_r   <= mixed_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lpn_r          <= lpn_nxt;
    wr_r           <= wr_nxt;
    scan_idx_r     <= scan_idx_nxt;
    free_found_r   <= free_found_nxt;
    free_idx_r     <= free_idx_nxt;
    ev_slot_r      <= ev_slot_nxt;
    cur_r          <= cur_nxt;
    push_clean_r   <= push_clean_nxt;
    op_r           <= op_nxt;
    drop_r         <= drop_nxt;
    iter_r         <= iter_nxt;
    bound_r        <= bound_nxt;
    out_hit_r      <= out_hit_nxt;
    out_fetch_r    <= out_fetch_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_lpn_r   <= out_ev_lpn_nxt;
    out_ev_wb_r    <= out_ev_wb_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_hit_kind        = out_hit_r;
  assign out_fetch_needed    = out_fetch_r;
  assign out_evict_valid     = out_ev_valid_r;
  assign out_evict_lpn       = out_ev_lpn_r;
  assign out_evict_writeback = out_ev_wb_r;
endmodule
`default_nettype wire

FILE: sv/ccflru_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ccflru_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [1:0] out_hit_kind,
  input wire logic       out_fetch_needed,
  input wire logic       out_evict_valid,
  input wire logic       out_evict_writeback
);
  import ccflru_pkg::*;

  // result shows as the engine goes idle
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item not taken");

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");

  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_kind != HIT_MISS) |->
      (!out_fetch_needed && !out_evict_valid)) else $error("hit with fetch/evict");

  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evict_writeback) |-> (out_evict_valid && out_fetch_needed))
    else $error("write-back without eviction");
endmodule

bind cold_clean_first_lru_policy ccflru_checker u_ccflru_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_hit_kind(out_hit_kind),
  .out_fetch_needed(out_fetch_needed), .out_evict_valid(out_evict_valid),
  .out_evict_writeback(out_evict_writeback)
);
`default_nettype wire

FILE: test/cold_clean_first_lru_policy_tb.sv
`timescale 1ns / 1ps
module cold_clean_first_lru_policy_tb;
  import ccflru_pkg::*;

  localparam int NSLOT = 64;

  typedef struct packed {
    logic [1:0]       hit_kind;
    logic             fetch_needed;
    logic             evict_valid;
    logic [LPN_W-1:0] evict_lpn;
    logic             evict_writeback;
  } access_res_t;

  class buffer_scoreboard;
    logic [CAP_W-1:0] cap_reg;
    logic [LPN_W-1:0] pg [NSLOT];
    bit vld [NSLOT];
    bit drt [NSLOT];
    bit cld [NSLOT];
    bit in_cl [NSLOT];
    int older [NSLOT];
    int newer [NSLOT];
    int cl_front, cl_tail, mx_front, mx_tail, cl_cnt, mx_cnt;
    access_res_t pending[$];
    int errors;

    function new();
      cap_reg = CAP_RESET;
      for (int i = 0; i < NSLOT; i++) begin
        vld[i] = 0; drt[i] = 0; cld[i] = 0; in_cl[i] = 0;
        older[i] = 0; newer[i] = 0; pg[i] = '0;
      end
      cl_front = 0; cl_tail = 0; mx_front = 0; mx_tail = 0;
      cl_cnt = 0; mx_cnt = 0; errors = 0;
    endfunction

    function void unlink(int s);
      int o, n;
      o = older[s];
      n = newer[s];
      if (in_cl[s]) begin
        if (cl_cnt == 0) return;
        if (cl_cnt > 1) begin
          if (s == cl_front) cl_front = o;
          else if (s == cl_tail) cl_tail = n;
          else begin newer[o] = n; older[n] = o; end
        end
        cl_cnt--;
      end else begin
        if (mx_cnt == 0) return;
        if (mx_cnt > 1) begin
          if (s == mx_front) mx_front = o;
          else if (s == mx_tail) mx_tail = n;
          else begin newer[o] = n; older[n] = o; end
        end
        mx_cnt--;
      end
    endfunction

    function void push(int s, bit clean);
      in_cl[s] = clean;
      if (clean) begin
        if (cl_cnt == 0) begin cl_front = s; cl_tail = s; end
        else begin newer[cl_front] = s; older[s] = cl_front; cl_front = s; end
        cl_cnt++;
      end else begin
        if (mx_cnt == 0) begin mx_front = s; mx_tail = s; end
        else begin newer[mx_front] = s; older[s] = mx_front; mx_front = s; end
        mx_cnt++;
      end
    endfunction

    function void drop(int s, ref access_res_t r);
      unlink(s);
      r.evict_valid = 1;
      r.evict_lpn = pg[s];
      r.evict_writeback = drt[s];
      vld[s] = 0; drt[s] = 0; cld[s] = 0; in_cl[s] = 0;
    endfunction

    function void pick_victim(ref access_res_t r);
      int bound, t;
      if (cl_cnt > 0) begin
        drop(cl_tail, r);
        return;
      end
      bound = 2 * mx_cnt + 2;
      for (int it = 0; it < bound && mx_cnt > 0; it++) begin
        t = mx_tail;
        if (!cld[t]) begin
          cld[t] = 1; unlink(t); push(t, 0);
        end else if (!drt[t]) begin
          unlink(t); push(t, 1);
        end else begin
          drop(t, r);
          return;
        end
      end
      if (cl_cnt > 0) drop(cl_tail, r);
    endfunction

    function void note_access(logic [LPN_W-1:0] lpn, logic rd);
      access_res_t r;
      int cap, hit, fr;
      r = '0;
      cap = cap_reg;
      if (cap == 0) cap = 1;
      if (cap > NSLOT) cap = NSLOT;
      hit = -1;
      for (int i = 0; i < NSLOT; i++)
        if (hit < 0 && vld[i] && pg[i] == lpn) hit = i;
      if (hit >= 0) begin
        r.hit_kind = in_cl[hit] ? HIT_CLEAN : HIT_MIXED;
        cld[hit] = 0;
        if (!rd) drt[hit] = 1;
        unlink(hit);
        push(hit, 0);
      end else begin
        r.hit_kind = HIT_MISS;
        r.fetch_needed = 1;
        if (cl_cnt + mx_cnt >= cap) pick_victim(r);
        fr = -1;
        for (int i = 0; i < NSLOT; i++)
          if (fr < 0 && !vld[i]) fr = i;
        if (fr >= 0) begin
          vld[fr] = 1; pg[fr] = lpn; cld[fr] = 1; drt[fr] = !rd;
          push(fr, rd);
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(access_res_t got);
      access_res_t e;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit_kind !== e.hit_kind) begin
        $error("hit_kind exp %0d got %0d", e.hit_kind, got.hit_kind); errors++;
      end
      if (got.fetch_needed !== e.fetch_needed) begin
        $error("fetch_needed exp %0d got %0d", e.fetch_needed, got.fetch_needed); errors++;
      end
      if (got.evict_valid !== e.evict_valid) begin
        $error("evict_valid exp %0d got %0d", e.evict_valid, got.evict_valid); errors++;
      end
      if (got.evict_lpn !== e.evict_lpn) begin
        $error("evict_lpn exp %h got %h", e.evict_lpn, got.evict_lpn); errors++;
      end
      if (got.evict_writeback !== e.evict_writeback) begin
        $error("evict_writeback exp %0d got %0d", e.evict_writeback,
               got.evict_writeback);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [LPN_W-1:0] in_lpn = '0;
  logic in_req_type = 0;
  logic out_valid;
  logic [1:0] out_hit_kind;
  logic out_fetch_needed, out_evict_valid, out_evict_writeback;
  logic [LPN_W-1:0] out_evict_lpn;
  logic cfg_we = 0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  buffer_scoreboard sb;
  int idle_pct;
  logic [LPN_W-1:0] page_pool [16];

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  cold_clean_first_lru_policy u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_lpn(in_lpn), .in_req_type(in_req_type),
    .out_valid(out_valid), .out_hit_kind(out_hit_kind),
    .out_fetch_needed(out_fetch_needed), .out_evict_valid(out_evict_valid),
    .out_evict_lpn(out_evict_lpn), .out_evict_writeback(out_evict_writeback),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_hit_kind, out_fetch_needed, out_evict_valid,
                       out_evict_lpn, out_evict_writeback});
  end

  // items are taken at the rising edge; drive at the falling edge
  task automatic send_access(logic [LPN_W-1:0] lpn, logic rd);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1;
    in_lpn <= lpn;
    in_req_type <= rd;
    @(posedge clk);
    sb.note_access(lpn, rd);
    @(negedge clk);
    start <= 0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() > 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (300) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.cap_reg = v;
  endtask

  // mostly reuse a small pool so hits and evictions happen often
  task automatic random_phase(int n, int pool_n);
    logic [LPN_W-1:0] p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) p = page_pool[$urandom_range(pool_n - 1)];
      else p = $urandom;
      send_access(p, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    for (int i = 0; i < 16; i++) page_pool[i] = $urandom;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, hits on both lists, clean-list and mixed-walk victims
    set_capacity(7'd2);
    send_access(32'h0000_0000, 1);
    send_access(32'hFFFF_FFFF, 0);
    send_access(32'h0000_0000, 1);
    send_access(32'h5555_5555, 1);
    send_access(32'hAAAA_AAAA, 0);
    send_access(32'hFFFF_FFFF, 1);
    send_access(32'h1234_5678, 0);
    send_access(32'h8765_4321, 0);
    send_access(32'h0F0F_0F0F, 1);
    send_access(32'h0F0F_0F0F, 0);
    send_access(32'hF0F0_F0F0, 0);
    set_capacity(7'd0);
    send_access(32'h0000_0001, 1);
    send_access(32'h0000_0002, 0);
    send_access(32'h0000_0002, 1);
    send_access(32'h0000_0003, 1);
    set_capacity(7'd127);
    send_access(32'h8000_0000, 0);
    send_access(32'h7FFF_FFFF, 1);
    set_capacity(7'd1);
    send_access(32'h0000_0004, 0);

    set_capacity(7'd4);
    random_phase(250, 8);
    idle_pct = 65;
    set_capacity(7'd64);
    for (int i = 0; i < 16; i++) page_pool[i] = $urandom;
    random_phase(250, 16);
    idle_pct = 32;
    set_capacity(7'd3);
    random_phase(250, 6);
    idle_pct = 0;
    set_capacity(7'd64);
    random_phase(100, 16);
    // capacity lowered below occupancy
    set_capacity(7'd5);
    random_phase(150, 12);
    idle_pct = 65;
    set_capacity(7'd1);
    random_phase(130, 4);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #200ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
